@@ rtl/fbot_pkg.sv @@
package fbot_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 12;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int END_BITS   = COORD_BITS + 2;
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int AREA_W     = 32;
  localparam int SEEN_W     = 7;
  localparam int PROD_W     = 2 * SIZE_BITS;
  localparam int SUM_W      = ((PROD_W > AREA_W) ? PROD_W : AREA_W) + 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  w;
    logic [SIZE_BITS-1:0]  h;
  } box_t;

  // One new box travelling down the row of cells.
  typedef struct packed {
    logic             valid;
    box_t             box;
    logic             hit;
    logic             store;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] remain;
  } token_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // Strict overlap: touching edges and empty boxes do not count.
  function automatic logic boxes_overlap(box_t a, box_t b);
    logic [END_BITS-1:0] a_hx;
    logic [END_BITS-1:0] a_hy;
    logic [END_BITS-1:0] b_hx;
    logic [END_BITS-1:0] b_hy;
    logic [END_BITS-1:0] lo_x;
    logic [END_BITS-1:0] lo_y;
    logic [END_BITS-1:0] hi_x;
    logic [END_BITS-1:0] hi_y;
    a_hx = END_BITS'(a.x) + END_BITS'(a.w);
    a_hy = END_BITS'(a.y) + END_BITS'(a.h);
    b_hx = END_BITS'(b.x) + END_BITS'(b.w);
    b_hy = END_BITS'(b.y) + END_BITS'(b.h);
    lo_x = (a.x > b.x) ? END_BITS'(a.x) : END_BITS'(b.x);
    lo_y = (a.y > b.y) ? END_BITS'(a.y) : END_BITS'(b.y);
    hi_x = (a_hx < b_hx) ? a_hx : b_hx;
    hi_y = (a_hy < b_hy) ? a_hy : b_hy;
    return (lo_x < hi_x) && (lo_y < hi_y);
  endfunction

endpackage

@@ rtl/fbot_in_if.sv @@
interface fbot_in_if;
  logic                    valid;
  logic                    ready;
  logic [11:0]             box_x;
  logic [11:0]             box_y;
  logic [12:0]             box_width;
  logic [12:0]             box_height;
  logic                    last_in_frame;
  logic                    empty_frame;

  modport source (
    output valid, box_x, box_y, box_width, box_height, last_in_frame, empty_frame,
    input  ready
  );
  modport sink (
    input  valid, box_x, box_y, box_width, box_height, last_in_frame, empty_frame,
    output ready
  );
endinterface

@@ rtl/fbot_out_if.sv @@
interface fbot_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] overlap_area;
  logic [6:0]  boxes_seen;
  logic        overflowed;

  modport source (
    output valid, overlap_area, boxes_seen, overflowed,
    input  ready
  );
  modport sink (
    input  valid, overlap_area, boxes_seen, overflowed,
    output ready
  );
endinterface

@@ rtl/fbot_cell.sv @@
module fbot_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              bank_sel,
  input  fbot_pkg::token_t  tok_in,
  output fbot_pkg::token_t  tok_out
);

  fbot_pkg::box_t   bank [2];
  fbot_pkg::token_t tok_next;
  logic             prev_here;

  // The cell holds a previous box while the remaining count is nonzero.
  always_comb begin
    prev_here       = (tok_in.remain != '0);
    tok_next        = tok_in;
    tok_next.hit    = tok_in.hit |
                      (prev_here & fbot_pkg::boxes_overlap(tok_in.box, bank[bank_sel]));
    tok_next.remain = prev_here ? tok_in.remain - 1'b1 : '0;
    tok_next.store  = tok_in.store & (tok_in.slot != '0);
    tok_next.slot   = tok_in.slot - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid && tok_in.store && (tok_in.slot == '0)) begin
      bank[~bank_sel] <= tok_in.box;
    end
  end

endmodule

@@ rtl/frame_box_overlap_tracker_core.sv @@
// Frame box overlap tracker.
// The boxes channel carries one bounding box per transfer, with last_in_frame
// on the final box of a frame, or a single transfer with empty_frame set for a
// frame without boxes. The result channel carries one transfer per frame:
// the saturating sum of the areas of the frame's boxes that strictly overlap
// any box of the previous frame, the number of boxes stored (capped at
// MAX_BOXES) and an overflow flag.
// Each accepted box runs down a row of MAX_BOXES cells, one cell per cycle;
// every cell holds one box of each bank and compares the passing box with its
// previous-frame box. Between one transfer and the next possible one a box
// passes through injection, the cell row and the update of the sums. A
// frame's final box then passes the finish state, which loads the result
// register; an empty frame goes from idle straight to the finish state.
// The result sits in an output register, so the next box is taken while a
// result still waits. Only the end of the following frame waits for the
// receiver to take the previous result.
// Reset is synchronous and active high. It clears all control state and
// starts with no previous frame, so the first frame reports zero. The cell
// storage needs no clearing: only entries written for the previous frame
// are ever compared.
module frame_box_overlap_tracker_core (
  input  logic       clk,
  input  logic       rst,
  fbot_in_if.sink    boxes,
  fbot_out_if.source result
);

  localparam int N = fbot_pkg::MAX_BOXES;

  fbot_pkg::state_t state;
  fbot_pkg::state_t state_next;

  // Token chain: entry 0 is the injection register, entry N leaves the last cell.
  fbot_pkg::token_t chain [N+1];
  fbot_pkg::token_t inj;

  logic                              bank_sel;
  logic [fbot_pkg::CNT_W-1:0]        previous_count;
  logic [fbot_pkg::CNT_W-1:0]        current_count;
  logic                              first_frame;
  logic [fbot_pkg::AREA_W-1:0]       area_sum;
  logic                              overflow_seen;
  logic [fbot_pkg::PROD_W-1:0]       prod;
  logic                              item_last;
  logic                              item_empty;

  logic                              out_valid;
  logic [fbot_pkg::AREA_W-1:0]       out_area;
  logic [fbot_pkg::SEEN_W-1:0]       out_seen;
  logic                              out_ovf;

  fbot_pkg::box_t                    new_box;
  logic                              in_xfer;
  logic                              sweep_done;
  logic                              finish_fire;
  logic                              has_room;
  logic [fbot_pkg::SUM_W-1:0]        sum_wide;
  logic [fbot_pkg::AREA_W-1:0]       sum_sat;

  assign chain[0] = inj;

  for (genvar g = 0; g < N; g++) begin : g_cell
    fbot_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .bank_sel (bank_sel),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  // Box fields are taken to the configured coordinate width.
  always_comb begin
    new_box.x = fbot_pkg::COORD_BITS'(boxes.box_x);
    new_box.y = fbot_pkg::COORD_BITS'(boxes.box_y);
    new_box.w = fbot_pkg::SIZE_BITS'(boxes.box_width);
    new_box.h = fbot_pkg::SIZE_BITS'(boxes.box_height);
  end

  assign has_room = (current_count < fbot_pkg::CNT_W'(N));
  assign sum_wide = fbot_pkg::SUM_W'(area_sum) + fbot_pkg::SUM_W'(prod);
  assign sum_sat  = (sum_wide > fbot_pkg::SUM_W'({fbot_pkg::AREA_W{1'b1}}))
                    ? {fbot_pkg::AREA_W{1'b1}} : fbot_pkg::AREA_W'(sum_wide);

  always_comb begin
    state_next  = state;
    boxes.ready = 1'b0;
    sweep_done  = 1'b0;
    finish_fire = 1'b0;
    unique case (state)
      fbot_pkg::ST_IDLE: begin
        // Nothing is taken while reset is held.
        boxes.ready = !rst;
        if (boxes.valid) begin
          state_next = boxes.empty_frame ? fbot_pkg::ST_FINISH : fbot_pkg::ST_SWEEP;
        end
      end
      fbot_pkg::ST_SWEEP: begin
        if (chain[N].valid) begin
          sweep_done = 1'b1;
          state_next = item_last ? fbot_pkg::ST_FINISH : fbot_pkg::ST_IDLE;
        end
      end
      fbot_pkg::ST_FINISH: begin
        if (!out_valid || result.ready) begin
          finish_fire = 1'b1;
          state_next  = fbot_pkg::ST_IDLE;
        end
      end
      default: state_next = fbot_pkg::ST_IDLE;
    endcase
  end

  assign in_xfer = boxes.valid && boxes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbot_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Injection register and per-item data.
  always_ff @(posedge clk) begin
    if (rst) begin
      inj <= '0;
    end else begin
      inj.valid <= 1'b0;
      if (in_xfer && !boxes.empty_frame) begin
        inj.valid  <= 1'b1;
        inj.box    <= new_box;
        inj.hit    <= 1'b0;
        inj.store  <= has_room;
        inj.slot   <= current_count;
        inj.remain <= first_frame ? '0 : previous_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_last  <= boxes.last_in_frame;
      item_empty <= boxes.empty_frame;
      prod       <= fbot_pkg::PROD_W'(new_box.w) * fbot_pkg::PROD_W'(new_box.h);
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_sel       <= 1'b0;
      previous_count <= '0;
      current_count  <= '0;
      first_frame    <= 1'b1;
      area_sum       <= '0;
      overflow_seen  <= 1'b0;
    end else if (sweep_done) begin
      if (chain[N].hit) begin
        area_sum <= sum_sat;
      end
      if (has_room) begin
        current_count <= current_count + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end else if (finish_fire) begin
      // An empty frame drops any partial frame and forgets the previous one.
      if (item_empty) begin
        previous_count <= '0;
        first_frame    <= 1'b1;
      end else begin
        bank_sel       <= ~bank_sel;
        previous_count <= current_count;
        first_frame    <= 1'b0;
      end
      current_count <= '0;
      area_sum      <= '0;
      overflow_seen <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      if (item_empty) begin
        out_area <= '0;
        out_seen <= '0;
        out_ovf  <= 1'b0;
      end else begin
        out_area <= area_sum;
        out_seen <= fbot_pkg::SEEN_W'(current_count);
        out_ovf  <= overflow_seen;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.overlap_area = out_area;
  assign result.boxes_seen   = out_seen;
  assign result.overflowed   = out_ovf;

endmodule

@@ rtl/fbot_checker.sv @@
module fbot_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] overlap_area,
  input logic [6:0]  boxes_seen,
  input logic        overflowed
);

  // A box transfer starts a sweep of the cell row, so no transfer follows at once.
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("box accepted in the cycle after a box transfer");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflowed |-> boxes_seen == 7'(fbot_pkg::MAX_BOXES))
    else $error("overflow reported with a table that is not full");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(overlap_area) && $stable(boxes_seen) && $stable(overflowed))
    else $error("result changed while stalled");

endmodule

bind frame_box_overlap_tracker_core fbot_checker u_fbot_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (boxes.valid),
  .in_ready     (boxes.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .overlap_area (result.overlap_area),
  .boxes_seen   (result.boxes_seen),
  .overflowed   (result.overflowed)
);

@@ tb/frame_box_overlap_tracker_core_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the frame box overlap tracker. Boxes go in on the
// boxes channel, one per transfer, and one report per frame comes back on the
// result channel. A bench-side tracker keeps its own two-bank copy of the box
// table and works out every report as the boxes are accepted. Each report
// that the block sends is checked field by field against the oldest report
// still due.
module frame_box_overlap_tracker_core_tb;

  localparam int ITEM_GOAL      = 700;
  localparam int TAIL_START     = 600;
  localparam int SAT_BOXES      = 258;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 25;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * fbot_pkg::MAX_BOXES + 10;
  localparam int N_DIRECTED     = 16;

  // One box as the sender drives it on the boxes channel.
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic        last;
    logic        empty;
  } box_item_t;

  // One frame report as it appears on the result channel.
  typedef struct packed {
    logic [31:0] area;
    logic [6:0]  seen;
    logic        ovf;
  } frame_report_t;

  // A row of the directed table. Where typed is set, the report in the row
  // is what the block must send, and it replaces the tracker's own answer.
  typedef struct packed {
    box_item_t     item;
    logic          typed;
    frame_report_t want;
  } step_row_t;

  // The directed rows walk through the special cases one frame at a time:
  // the first frame after reset, corner and edge contact, boxes with no width
  // or height, an empty frame with every box field at its top value, a frame
  // cut short by an empty frame, and the first frame after each empty one.
  localparam step_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // First frame after reset reports zero area.
    '{'{12'd0,    12'd0,    13'd4096, 13'd4096, 1'b1, 1'b0}, 1'b1, '{32'd0, 7'd1, 1'b0}},
    // Corner overlap with the full-size box, then a box of zero width.
    '{'{12'd4095, 12'd4095, 13'd4096, 13'd4096, 1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd100,  12'd100,  13'd0,    13'd50,   1'b1, 1'b0}, 1'b0, '0},
    // Edge contact only, a real overlap, a box of zero height, no contact.
    '{'{12'd0,    12'd0,    13'd4095, 13'd4095, 1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd4094, 12'd4094, 13'd2,    13'd2,    1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd4095, 12'd4095, 13'd4096, 13'd0,    1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd100,  12'd90,   13'd1,    13'd4096, 1'b1, 1'b0}, 1'b0, '0},
    // Empty frame; the box fields carry their top values and are ignored.
    '{'{12'd4095, 12'd4095, 13'd4096, 13'd4096, 1'b1, 1'b1}, 1'b1, '{32'd0, 7'd0, 1'b0}},
    '{'{12'd10,   12'd10,   13'd20,   13'd20,   1'b1, 1'b0}, 1'b1, '{32'd0, 7'd1, 1'b0}},
    // Inside, corner contact, a one-pixel overlap, edge contact.
    '{'{12'd15,   12'd15,   13'd5,    13'd5,    1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd0,    12'd0,    13'd10,   13'd10,   1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd29,   12'd29,   13'd1,    13'd1,    1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd30,   12'd10,   13'd4,    13'd4,    1'b1, 1'b0}, 1'b0, '0},
    // A frame dropped halfway by an empty frame without last_in_frame.
    '{'{12'd12,   12'd12,   13'd3,    13'd3,    1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd0,    12'd0,    13'd0,    13'd0,    1'b0, 1'b1}, 1'b1, '{32'd0, 7'd0, 1'b0}},
    '{'{12'd0,    12'd0,    13'd1,    13'd1,    1'b1, 1'b0}, 1'b1, '{32'd0, 7'd1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst;

  fbot_in_if  boxes ();
  fbot_out_if result ();

  frame_box_overlap_tracker_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .boxes  (boxes),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reports that the block still owes, oldest first.
  frame_report_t frame_reports_due [$];

  // The bench's own copy of the tracker state. The bank named by prev_bank
  // holds the previous frame; the other bank fills with the current one.
  fbot_pkg::box_t frame_boxes [2][fbot_pkg::MAX_BOXES];
  bit          prev_bank;
  int unsigned prev_cnt;
  int unsigned cur_cnt;
  bit          no_prev;
  logic [31:0] run_area;
  bit          cur_ovf;

  int unsigned items_sent;
  int unsigned results_taken;
  int unsigned mismatches;
  int unsigned frames_closed;
  int unsigned empty_frames;
  int unsigned overlap_boxes;
  int unsigned overflow_frames;
  int unsigned saturated_frames;
  int unsigned quiet_cycles;

  bit quiet_tail;
  bit tx_calm;

  // Strict overlap on the right and bottom edges, computed wide enough
  // that x + w never wraps.
  function automatic bit strictly_overlapping(fbot_pkg::box_t a, fbot_pkg::box_t b);
    int unsigned left;
    int unsigned top;
    int unsigned right;
    int unsigned bottom;
    int unsigned a_end;
    int unsigned b_end;
    left   = (a.x > b.x) ? a.x : b.x;
    top    = (a.y > b.y) ? a.y : b.y;
    a_end  = a.x;
    a_end  = a_end + a.w;
    b_end  = b.x;
    b_end  = b_end + b.w;
    right  = (a_end < b_end) ? a_end : b_end;
    a_end  = a.y;
    a_end  = a_end + a.h;
    b_end  = b.y;
    b_end  = b_end + b.h;
    bottom = (a_end < b_end) ? a_end : b_end;
    return (left < right) && (top < bottom);
  endfunction

  // Advances the bench tracker by one accepted box. Returns 1 when the box
  // closes a frame, with the report the block must send for it.
  function automatic bit track_box(input box_item_t in, output frame_report_t rep);
    fbot_pkg::box_t  nb;
    bit              hit;
    longint unsigned sum;
    rep = '0;
    if (in.empty) begin
      // An empty frame wipes the previous frame and any partial one.
      prev_cnt = 0;
      cur_cnt  = 0;
      no_prev  = 1'b1;
      run_area = '0;
      cur_ovf  = 1'b0;
      empty_frames++;
      return 1'b1;
    end
    nb.x = in.x[fbot_pkg::COORD_BITS-1:0];
    nb.y = in.y[fbot_pkg::COORD_BITS-1:0];
    nb.w = in.w[fbot_pkg::SIZE_BITS-1:0];
    nb.h = in.h[fbot_pkg::SIZE_BITS-1:0];
    hit  = 1'b0;
    if (!no_prev) begin
      for (int unsigned j = 0; j < prev_cnt && !hit; j++) begin
        hit = strictly_overlapping(nb, frame_boxes[prev_bank][j]);
      end
    end
    if (hit) begin
      overlap_boxes++;
      sum = longint'(run_area) + longint'(nb.w) * longint'(nb.h);
      run_area = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    end
    // Boxes past capacity still count toward the area but are not kept.
    if (cur_cnt < fbot_pkg::MAX_BOXES) begin
      frame_boxes[!prev_bank][cur_cnt] = nb;
      cur_cnt++;
    end else begin
      cur_ovf = 1'b1;
    end
    if (!in.last) return 1'b0;
    rep.area = run_area;
    rep.seen = cur_cnt[6:0];
    rep.ovf  = cur_ovf;
    frames_closed++;
    if (cur_ovf) overflow_frames++;
    if (run_area == 32'hFFFF_FFFF) saturated_frames++;
    prev_bank = !prev_bank;
    prev_cnt  = cur_cnt;
    cur_cnt   = 0;
    no_prev   = 1'b0;
    run_area  = '0;
    cur_ovf   = 1'b0;
    return 1'b1;
  endfunction

  // Most random boxes sit in one small corner so that frames overlap often.
  // The rest spread over the whole range, with full width or full height now
  // and then so that the top bit of each size field is exercised.
  function automatic box_item_t random_box();
    box_item_t   b;
    int unsigned pick;
    b    = '0;
    pick = $urandom_range(0, 19);
    if (pick <= 5) begin
      b.x = 12'($urandom_range(0, 4095));
      b.y = 12'($urandom_range(0, 4095));
      b.w = (pick == 0) ? 13'd4096 : 13'($urandom_range(0, 4096));
      b.h = (pick == 1) ? 13'd4096 : 13'($urandom_range(0, 4096));
    end else begin
      b.x = 12'($urandom_range(0, 191));
      b.y = 12'($urandom_range(0, 191));
      b.w = 13'($urandom_range(0, 64));
      b.h = 13'($urandom_range(0, 64));
    end
    return b;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%t MISMATCH report %0d %s: got %0d, want %0d",
             $realtime, results_taken, what, got, want);
  endtask

  // Drives one box and holds it until the block takes it. The tracker's
  // report is queued unless the caller supplies one read off the table.
  task automatic send_box(input box_item_t it, input bit typed, input frame_report_t want);
    frame_report_t rep;
    boxes.valid         <= 1'b1;
    boxes.box_x         <= it.x;
    boxes.box_y         <= it.y;
    boxes.box_width     <= it.w;
    boxes.box_height    <= it.h;
    boxes.last_in_frame <= it.last;
    boxes.empty_frame   <= it.empty;
    @(posedge clk);
    while (!boxes.ready) @(posedge clk);
    items_sent++;
    if (track_box(it, rep)) frame_reports_due.push_back(typed ? want : rep);
  endtask

  // A burst of idle cycles on the sender side, now and then.
  task automatic maybe_gap();
    if (!quiet_tail && !tx_calm && $urandom_range(0, 3) == 0) begin
      boxes.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // The sender stops until the block has sent every report it owes.
  task automatic wait_drained();
    if (frame_reports_due.size() != 0) begin
      boxes.valid <= 1'b0;
      while (frame_reports_due.size() != 0) @(posedge clk);
    end
  endtask

  // A frame of n boxes. Full-size boxes all overlap a full-size box at the
  // origin, which is how the area sum is driven into saturation.
  task automatic send_frame(input int unsigned n, input bit full_size);
    box_item_t b;
    for (int unsigned i = 0; i < n; i++) begin
      if (full_size) begin
        b   = '0;
        b.x = 12'($urandom_range(0, 4095));
        b.y = 12'($urandom_range(0, 4095));
        b.w = 13'd4096;
        b.h = 13'd4096;
      end else begin
        b = random_box();
      end
      b.last = (i == n - 1);
      maybe_gap();
      send_box(b, 1'b0, '0);
    end
  endtask

  task automatic send_empty();
    box_item_t b;
    b       = random_box();
    b.last  = 1'($urandom_range(0, 1));
    b.empty = 1'b1;
    maybe_gap();
    send_box(b, 1'b0, '0);
  endtask

  // Result side: checks every report transfer against the oldest one due.
  always @(posedge clk) begin
    frame_report_t want;
    if (!rst && result.valid && result.ready) begin
      results_taken++;
      if (frame_reports_due.size() == 0) begin
        flag_mismatch("arrived with no report due, area", result.overlap_area, 0);
      end else begin
        want = frame_reports_due.pop_front();
        if (result.overlap_area !== want.area)
          flag_mismatch("overlap_area", result.overlap_area, want.area);
        if (result.boxes_seen !== want.seen)
          flag_mismatch("boxes_seen", result.boxes_seen, want.seen);
        if (result.overflowed !== want.ovf)
          flag_mismatch("overflowed", result.overflowed, want.ovf);
      end
    end
  end

  // Receiver ready. Outside the tail it stalls in short bursts, in windows
  // that are picked at random to be stalling or calm. Once, early on, it holds ready
  // low for a long stretch so that the output register stays full and the
  // block has to push back on the boxes channel.
  int unsigned rx_stall_left;
  int unsigned rx_hold_left;
  int unsigned rx_window;
  bit          rx_hold_done;
  bit          rx_calm;

  always @(posedge clk) begin
    if (rst) begin
      result.ready  <= 1'b0;
      rx_stall_left = 0;
      rx_hold_left  = 0;
      rx_window     = 0;
      rx_hold_done  = 1'b0;
      rx_calm       = 1'b0;
    end else begin
      rx_window++;
      if (rx_window % 256 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (!rx_hold_done && results_taken >= HOLD_AFTER) begin
        rx_hold_done = 1'b1;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        result.ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        result.ready <= 1'b0;
      end else if (!quiet_tail && !rx_calm && $urandom_range(0, 3) == 0) begin
        rx_stall_left = $urandom_range(0, 6);
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either channel
  // means the block has hung.
  always @(posedge clk) begin
    if (rst || (boxes.valid && boxes.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%t watchdog: no transfer for %0d cycles, %0d reports still due",
               $realtime, WATCHDOG_LIMIT, frame_reports_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned frame_no;
    int unsigned kind;
    box_item_t   origin_box;

    rst                 = 1'b1;
    boxes.valid         = 1'b0;
    boxes.box_x         = '0;
    boxes.box_y         = '0;
    boxes.box_width     = '0;
    boxes.box_height    = '0;
    boxes.last_in_frame = 1'b0;
    boxes.empty_frame   = 1'b0;
    quiet_tail          = 1'b0;
    tx_calm             = 1'b0;
    prev_bank           = 1'b0;
    prev_cnt            = 0;
    cur_cnt             = 0;
    no_prev             = 1'b1;
    run_area            = '0;
    cur_ovf             = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table first.
    for (int i = 0; i < N_DIRECTED; i++) begin
      maybe_gap();
      send_box(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    wait_drained();

    // Random frames. A few fixed slots carry the large cases: a frame of
    // exactly MAX_BOXES boxes, a saturating frame that also overflows, and
    // an overflowing frame of ordinary boxes. The rest are short frames,
    // with empty frames and frames broken off by an empty frame mixed in.
    frame_no = 0;
    while (items_sent < ITEM_GOAL) begin
      quiet_tail = (items_sent >= TAIL_START);
      if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
      if (frame_no == 8) begin
        send_frame(fbot_pkg::MAX_BOXES, 1'b0);
      end else if (frame_no == 20) begin
        wait_drained();
        origin_box      = '0;
        origin_box.w    = 13'd4096;
        origin_box.h    = 13'd4096;
        origin_box.last = 1'b1;
        maybe_gap();
        send_box(origin_box, 1'b0, '0);
        send_frame(SAT_BOXES, 1'b1);
      end else if (frame_no == 35) begin
        send_frame(fbot_pkg::MAX_BOXES + $urandom_range(1, 6), 1'b0);
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          send_empty();
        end else if (kind < 13) begin
          // Boxes without last_in_frame, then an empty frame drops them.
          for (int unsigned k = $urandom_range(1, 4); k != 0; k--) begin
            origin_box      = random_box();
            maybe_gap();
            send_box(origin_box, 1'b0, '0);
          end
          send_empty();
        end else if (kind < 17) begin
          wait_drained();
          send_frame($urandom_range(1, 6), 1'b0);
        end else if (kind < 25) begin
          send_frame($urandom_range(7, 16), 1'b0);
        end else begin
          send_frame($urandom_range(1, 6), 1'b0);
        end
      end
      frame_no++;
    end
    boxes.valid <= 1'b0;

    // Let the block send what it owes, then watch a while for anything extra.
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d boxes in %0d closed frames and %0d empty frames;",
             items_sent, frames_closed, empty_frames);
    $display("%0d boxes overlapped, %0d frames went past capacity, %0d sums saturated, %0d reports checked.",
             overlap_boxes, overflow_frames, saturated_frames, results_taken);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fbot_pkg.sv
rtl/fbot_in_if.sv
rtl/fbot_out_if.sv
rtl/fbot_cell.sv
rtl/frame_box_overlap_tracker_core.sv
rtl/fbot_checker.sv
tb/frame_box_overlap_tracker_core_tb.sv
